@@ rtl/rdc_pkg.sv @@
// Shared constants, types and controller state encoding for the radix digit converter.
package rdc_pkg;

    // Field widths fixed by the interface
    localparam int FIELD_WIDTH       = 32;
    localparam int RADIX_W           = 5;
    localparam int DIGIT_W           = 4;

    // Default width of the converted value
    localparam int VALUE_WIDTH_DEF   = 32;

    // Digit store geometry
    localparam int STORE_DEPTH       = 32;
    localparam int IDX_W             = $clog2(STORE_DEPTH);

    // Dividend bits consumed per divide cycle
    localparam int STEP_BITS         = 8;

    // Legal radix range and reset value
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_READ,
        ST_SHOW
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic rd_first;
        logic rd_next;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic value_zero;
        logic chunk_last;
        logic quot_zero;
        logic rd_last;
    } dp_stat_t;

endpackage

@@ rtl/radix_digit_converter_top.sv @@
// Top level of the radix digit converter: controller plus datapath.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------
//  value in  | value_valid / value_stall  | whole_value[31:0]
//  digit out | digit_valid / digit_stall  | digit[3:0], last_digit
//  radix cfg | radix_wr_en                | radix_wr_data[4:0]
//
// Each digit passes the VW-bit value through the 8-bit-per-cycle remainder chain,
// VW = min(VALUE_WIDTH, 32); a zero value is taken and gives no word.
// Reset clears control and sets radix to 10; the digit store is not cleared.
// value_stall is high from acceptance until the last digit word is taken;
// digit_stall holds the current word in place.
module radix_digit_converter_top #(
    parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              radix_wr_en,
    input  logic [rdc_pkg::RADIX_W-1:0]       radix_wr_data,
    input  logic                              value_valid,
    output logic                              value_stall,
    input  logic [rdc_pkg::FIELD_WIDTH-1:0]   whole_value,
    output logic                              digit_valid,
    input  logic                              digit_stall,
    output logic [rdc_pkg::DIGIT_W-1:0]       digit,
    output logic                              last_digit
);
    import rdc_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer
    rdc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_stall (value_stall),
        .digit_valid (digit_valid),
        .digit_stall (digit_stall),
        .cmd         (cmd),
        .stat        (stat)
    );

    // Divider and digit store
    rdc_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .radix_wr_en   (radix_wr_en),
        .radix_wr_data (radix_wr_data),
        .whole_value   (whole_value),
        .cmd           (cmd),
        .stat          (stat),
        .digit         (digit),
        .last_digit    (last_digit)
    );

endmodule

@@ rtl/rdc_datapath.sv @@
// Datapath: radix register, chunked long divider, digit store and output read.
module rdc_datapath #(
    parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          radix_wr_en,
    input  logic [rdc_pkg::RADIX_W-1:0]   radix_wr_data,
    input  logic [rdc_pkg::FIELD_WIDTH-1:0] whole_value,
    input  rdc_pkg::dp_cmd_t              cmd,
    output rdc_pkg::dp_stat_t             stat,
    output logic [rdc_pkg::DIGIT_W-1:0]   digit,
    output logic                          last_digit
);
    import rdc_pkg::*;

    // Effective value width is capped by the input field
    localparam int VW     = (VALUE_WIDTH < FIELD_WIDTH) ? VALUE_WIDTH : FIELD_WIDTH;
    localparam int CHUNKS = (VW + STEP_BITS - 1) / STEP_BITS;
    localparam int PW     = CHUNKS * STEP_BITS;
    localparam int CNT_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

    logic [RADIX_W-1:0]  radix_reg;
    logic [PW-1:0]       val_reg;
    logic [PW-1:0]       val_next;
    logic [DIGIT_W-1:0]  rem_reg;
    logic [DIGIT_W-1:0]  rem_next;
    logic [CNT_W-1:0]    chunk_reg;
    logic [IDX_W-1:0]    wr_idx_reg;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic [IDX_W-1:0]    rd_addr;
    logic [DIGIT_W-1:0]  rd_data_reg;
    logic [STEP_BITS-1:0] qbits;
    logic                chunk_last;
    logic                digit_done;
    logic [DIGIT_W-1:0]  store_mem [STORE_DEPTH];

    // Accept legal radix writes, drop the rest
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (radix_wr_en && radix_wr_data >= RADIX_MIN && radix_wr_data <= RADIX_MAX)
        begin
            radix_reg <= radix_wr_data;
        end
    end

    // One chunk of restoring long division, one dividend bit per step
    always_comb
    begin
        logic [DIGIT_W:0] t;
        logic [DIGIT_W-1:0] r;
        r = rem_reg;
        qbits = '0;
        for (int i = 0; i < STEP_BITS; i++)
        begin
            t = {r, val_reg[PW-1-i]};
            if (t >= radix_reg)
            begin
                t = t - radix_reg;
                qbits[STEP_BITS-1-i] = 1'b1;
            end
            r = t[DIGIT_W-1:0];
        end
        rem_next = r;
        val_next = (val_reg << STEP_BITS) | PW'(qbits);
    end

    assign chunk_last = (chunk_reg == CNT_W'(CHUNKS - 1));
    assign digit_done = cmd.step && chunk_last;

    // Advance the divider; clear remainder at the start of each digit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg    <= '0;
            chunk_reg  <= '0;
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
        end
        else if (cmd.load)
        begin
            rem_reg    <= '0;
            chunk_reg  <= '0;
            wr_idx_reg <= '0;
        end
        else if (cmd.step)
        begin
            if (chunk_last)
            begin
                rem_reg    <= '0;
                chunk_reg  <= '0;
                wr_idx_reg <= wr_idx_reg + 1'b1;
                rd_idx_reg <= wr_idx_reg;
            end
            else
            begin
                rem_reg   <= rem_next;
                chunk_reg <= chunk_reg + 1'b1;
            end
        end
        else if (cmd.rd_next)
        begin
            rd_idx_reg <= rd_addr;
        end
    end

    // Dividend register, refilled with quotient bits as it shifts
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            val_reg <= PW'(whole_value[VW-1:0]);
        end
        else if (cmd.step)
        begin
            val_reg <= val_next;
        end
    end

    // Digit store: write the finished remainder, registered read
    assign rd_addr = cmd.rd_next ? (rd_idx_reg - 1'b1) : rd_idx_reg;

    always_ff @(posedge clk)
    begin
        if (digit_done)
        begin
            store_mem[wr_idx_reg] <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_first || cmd.rd_next)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // Status and output word
    assign stat.value_zero = (whole_value[VW-1:0] == '0);
    assign stat.chunk_last = chunk_last;
    assign stat.quot_zero  = (val_next == '0);
    assign stat.rd_last    = (rd_idx_reg == '0);

    assign digit      = rd_data_reg;
    assign last_digit = (rd_idx_reg == '0);

`ifndef ASSERT_OFF
    // Remainder always stays below the radix
    a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg < radix_reg)
        else $error("remainder not below radix");

    // Radix register never leaves the legal range
    a_radix_legal: assert property (@(posedge clk) disable iff (!rst_n)
        radix_reg >= RADIX_MIN && radix_reg <= RADIX_MAX)
        else $error("radix register out of range");

    // A finished digit leaves the remainder cleared
    a_rem_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        digit_done |=> rem_reg == '0)
        else $error("remainder not cleared after digit");
`endif

endmodule

@@ rtl/rdc_ctrl.sv @@
// Controller: sequences load, divide, store readback and digit handoff.
module rdc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              value_valid,
    output logic              value_stall,
    output logic              digit_valid,
    input  logic              digit_stall,
    output rdc_pkg::dp_cmd_t  cmd,
    input  rdc_pkg::dp_stat_t stat
);
    import rdc_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (value_valid && !stat.value_zero)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (stat.chunk_last && stat.quot_zero)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                if (!digit_stall && stat.rd_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands
    always_comb
    begin
        cmd         = '0;
        value_stall = 1'b1;
        digit_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                value_stall = 1'b0;
                cmd.load    = value_valid;
            end
            ST_DIVIDE:
            begin
                cmd.step = 1'b1;
            end
            ST_READ:
            begin
                cmd.rd_first = 1'b1;
            end
            ST_SHOW:
            begin
                digit_valid = 1'b1;
                cmd.rd_next = !digit_stall && !stat.rd_last;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // Input is held off while a digit is offered
    a_busy_while_showing: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid |-> value_stall)
        else $error("input taken while digit pending");

    // Taking the last digit ends the run
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (digit_valid && !digit_stall && stat.rd_last) |=> !digit_valid)
        else $error("digit offered after last digit");

    // A run of digits starts only after a store read
    a_show_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(digit_valid) |-> $past(state_reg) == ST_READ)
        else $error("digit offered without store read");
`endif

endmodule

@@ test/tb_radix_digit_converter_top.sv @@
// Self-checking testbench for the radix digit converter: random and directed values.
module tb_radix_digit_converter_top;

    timeunit 1ns;
    timeprecision 1ps;

    import rdc_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 200;
    localparam int STALL_LIMIT   = 5000;
    localparam int MAX_PRINTED   = 30;
    localparam int CONV_WIDTH    = VALUE_WIDTH_DEF;
    localparam int PHASES        = 3;
    localparam int GROUPS        = 11;
    localparam int GROUP_ITEMS   = 15;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } digit_word_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   radix_wr_en = 1'b0;
    logic [RADIX_W-1:0]     radix_wr_data = '0;
    logic                   value_valid = 1'b0;
    logic                   value_stall;
    logic [FIELD_WIDTH-1:0] whole_value = '0;
    logic                   digit_valid;
    logic                   digit_stall = 1'b0;
    logic [DIGIT_W-1:0]     digit;
    logic                   last_digit;

    // Stimulus and expectation stores
    logic [FIELD_WIDTH-1:0] pending_values[$];
    digit_word_t            expected_digits[$];
    logic [RADIX_W-1:0]     conv_radix = RADIX_RESET;

    // Handshake bookkeeping
    logic value_taken = 1'b0;
    logic quiet = 1'b0;
    int   sender_idle_pct = 0;
    int   receiver_stall_pct = 0;
    int   idle_cycles = 0;
    bit   progress;

    // Run statistics
    int mismatches = 0;
    int values_taken = 0;
    int digits_checked = 0;
    int radix_writes = 0;

    digit_word_t got_word;
    digit_word_t exp_word;

    radix_digit_converter_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .radix_wr_en   (radix_wr_en),
        .radix_wr_data (radix_wr_data),
        .value_valid   (value_valid),
        .value_stall   (value_stall),
        .whole_value   (whole_value),
        .digit_valid   (digit_valid),
        .digit_stall   (digit_stall),
        .digit         (digit),
        .last_digit    (last_digit)
    );

    always #HALF_PERIOD clk = ~clk;

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("%0t ERROR: %s", $time, what);
    endtask

    // Divide by the current radix, then queue the remainders most significant first
    function automatic void predict_digits(input logic [FIELD_WIDTH-1:0] value);
        logic [63:0]        rest;
        logic [DIGIT_W-1:0] rems[STORE_DEPTH];
        int                 n;
        digit_word_t        w;
        rest = 64'(value) & ((64'd1 << CONV_WIDTH) - 64'd1);
        n = 0;
        while (rest != 0 && n < STORE_DEPTH)
        begin
            rems[n] = DIGIT_W'(rest % 64'(conv_radix));
            rest = rest / 64'(conv_radix);
            n++;
        end
        for (int k = n - 1; k >= 0; k--)
        begin
            w.digit = rems[k];
            w.last  = (k == 0);
            expected_digits.push_back(w);
        end
    endfunction

    // Mix of zero, full-range, narrow, small, radix-power boundary and near-all-ones values
    function automatic logic [FIELD_WIDTH-1:0] pick_value();
        logic [63:0] p;
        int          k;
        unique case ($urandom_range(9))
            0:       return '0;
            1, 2, 3: return $urandom;
            4, 5, 6: return $urandom >> $urandom_range(31);
            7:       return FIELD_WIDTH'($urandom_range(0, 300));
            8:
            begin
                p = 64'd1;
                k = $urandom_range(1, STORE_DEPTH);
                repeat (k)
                    if (p <= 64'hFFFF_FFFF)
                        p = p * 64'(conv_radix);
                if (p > 64'hFFFF_FFFF)
                    p = 64'h1_0000_0000;
                return FIELD_WIDTH'(p - 64'($urandom_range(0, 1)));
            end
            default: return 32'hFFFF_FFFF ^ (32'd1 << $urandom_range(31));
        endcase
    endfunction

    // Mostly legal, with the extremes and rejected codes well represented
    function automatic logic [RADIX_W-1:0] pick_radix();
        unique case ($urandom_range(9))
            0, 1:    return RADIX_MIN;
            2, 3:    return RADIX_MAX;
            4, 5:    return RADIX_W'($urandom_range(0, 31));
            default: return RADIX_W'($urandom_range(2, 16));
        endcase
    endfunction

    // Wait until every value is taken and every digit has arrived, then let the block settle
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (!quiet);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_radix(input logic [RADIX_W-1:0] value);
        wait_quiet();
        radix_wr_en   <= 1'b1;
        radix_wr_data <= value;
        @(negedge clk);
        radix_wr_en   <= 1'b0;
    endtask

    task automatic queue_value(input logic [FIELD_WIDTH-1:0] value);
        pending_values.push_back(value);
    endtask

    // Driver: present words from the pending queue, hold them while stalled, drive random digit stalls
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            value_valid <= 1'b0;
            digit_stall <= 1'b0;
        end
        else
        begin
            if (!value_valid || value_taken)
            begin
                if (pending_values.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    value_valid <= 1'b1;
                    whole_value <= pending_values.pop_front();
                end
                else
                    value_valid <= 1'b0;
            end
            digit_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // Monitor: track config, predict on each taken value, check each taken digit word
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            conv_radix  = RADIX_RESET;
            value_taken <= 1'b0;
            quiet       <= 1'b1;
            idle_cycles = 0;
        end
        else
        begin
            progress = 1'b0;
            if (radix_wr_en)
            begin
                radix_writes++;
                progress = 1'b1;
                if (radix_wr_data >= RADIX_MIN && radix_wr_data <= RADIX_MAX)
                    conv_radix = radix_wr_data;
            end
            if (digit_valid && !digit_stall)
            begin
                digits_checked++;
                progress = 1'b1;
                got_word.digit = digit;
                got_word.last  = last_digit;
                if (expected_digits.size() == 0)
                    report_mismatch($sformatf("unexpected digit word %h last=%b",
                                              got_word.digit, got_word.last));
                else
                begin
                    exp_word = expected_digits.pop_front();
                    if (got_word.digit !== exp_word.digit)
                        report_mismatch($sformatf("digit %h, expected %h",
                                                  got_word.digit, exp_word.digit));
                    if (got_word.last !== exp_word.last)
                        report_mismatch($sformatf("last_digit %b, expected %b",
                                                  got_word.last, exp_word.last));
                end
            end
            if (value_valid && !value_stall)
            begin
                values_taken++;
                progress = 1'b1;
                predict_digits(whole_value);
            end
            value_taken <= value_valid && !value_stall;
            quiet <= (pending_values.size() == 0) && !(value_valid && value_stall)
                     && (expected_digits.size() == 0);
            // Abort when nothing moves for too long
            if (progress)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t ERROR: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("tb_radix_digit_converter_top: FAIL");
                $finish;
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        sender_idle_pct    = 32;
        receiver_stall_pct = 76;

        // Reset radix of ten: zero, single digits, carry into a second digit, full range
        queue_value(32'd0);
        queue_value(32'd1);
        queue_value(32'd9);
        queue_value(32'd10);
        queue_value(32'hFFFF_FFFF);
        queue_value(32'd123456789);

        // Binary: the full 32-digit conversion and a lone top bit
        write_radix(RADIX_MIN);
        queue_value(32'hFFFF_FFFF);
        queue_value(32'h8000_0000);
        queue_value(32'd1);

        // Hex: top digit value and radix boundaries
        write_radix(RADIX_MAX);
        queue_value(32'hDEAD_BEEF);
        queue_value(32'd15);
        queue_value(32'd16);
        queue_value(32'hF000_0000);

        // Rejected writes leave hex in place
        write_radix(5'd0);
        write_radix(5'd1);
        write_radix(5'd17);
        write_radix(5'd31);
        queue_value(32'hFFFF_FFFF);

        write_radix(5'd3);
        queue_value(32'hFFFF_FFFF);
        queue_value(32'h5555_5555);
        write_radix(5'd7);
        queue_value(32'hAAAA_AAAA);

        // Random part: slow sender and busy receiver, then swapped, then full speed
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_quiet();
            unique case (phase)
                0:
                begin
                    sender_idle_pct    = 32;
                    receiver_stall_pct = 76;
                end
                1:
                begin
                    sender_idle_pct    = 76;
                    receiver_stall_pct = 32;
                end
                default:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
            endcase
            for (int g = 0; g < GROUPS; g++)
            begin
                write_radix(pick_radix());
                repeat (GROUP_ITEMS) queue_value(pick_value());
            end
        end

        wait_quiet();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (expected_digits.size() != 0)
            report_mismatch($sformatf("%0d digit words never arrived", expected_digits.size()));

        $display("Run covered %0d values and %0d digit words over %0d radix writes,",
                 values_taken, digits_checked, radix_writes);
        $display("with radix 2 to 16, rejected codes, and three sender/receiver idling mixes.");
        if (mismatches == 0)
            $display("tb_radix_digit_converter_top: PASS");
        else
            $display("tb_radix_digit_converter_top: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/rdc_pkg.sv
rtl/rdc_datapath.sv
rtl/rdc_ctrl.sv
rtl/radix_digit_converter_top.sv
test/tb_radix_digit_converter_top.sv
